/* rtl/dbs_pkg.sv */
// ----------------------------------------------------------------------------
// dbs_pkg
// Shared types and constants for the double-ended queue and bag store.
// ----------------------------------------------------------------------------
`default_nettype none

package dbs_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int DATA_W        = 32;
   localparam int KIND_W        = 3;
   localparam int STATUS_W      = 2;
   localparam int COUNT_W       = 7;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH_FRONT = 3'd0,
      KIND_PUSH_BACK  = 3'd1,
      KIND_POP_FRONT  = 3'd2,
      KIND_POP_BACK   = 3'd3,
      KIND_CONTAINS   = 3'd4,
      KIND_REMOVE     = 3'd5
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SEARCH,
      ST_SHIFT,
      ST_RD_FRONT,
      ST_RD_BACK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic                     found;
      logic signed [DATA_W-1:0] front_value;
      logic signed [DATA_W-1:0] back_value;
      logic [COUNT_W-1:0]       count;
      logic                     is_empty;
   } rsp_type;

endpackage

`default_nettype wire

/* rtl/deque_bag_store_core.sv */
// ----------------------------------------------------------------------------
// deque_bag_store_core
// Bounded double-ended queue of signed 32-bit values, also usable as a bag
// with membership test and removal of the first occurrence of a value.
//
//   channel   direction  handshake              payload
//   req       in         req_valid/req_ready    req_kind, req_value
//   rsp       out        rsp_valid/rsp_ready    rsp_status, rsp_found,
//                                               rsp_front_value, rsp_back_value,
//                                               rsp_count, rsp_is_empty
//
// pushes, pops and unused kinds: dispatch, front read, back read, result item
// contains and remove read one entry a cycle until a hit or the end, and a
// remove that hits closes the gap in the same walk
// ready again as the result item turns valid; one item is in work at a time
// reset clears head and count; entries need no clearing
// a waiting result item sits in an output register, next item accepted meanwhile
// ----------------------------------------------------------------------------
`default_nettype none

module deque_bag_store_core #(
   parameter int DEPTH = dbs_pkg::DEPTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output      logic                              req_ready,
   input  wire logic [dbs_pkg::KIND_W-1:0]        req_kind,
   input  wire logic signed [dbs_pkg::DATA_W-1:0] req_value,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   output      logic [dbs_pkg::STATUS_W-1:0]      rsp_status,
   output      logic                              rsp_found,
   output      logic signed [dbs_pkg::DATA_W-1:0] rsp_front_value,
   output      logic signed [dbs_pkg::DATA_W-1:0] rsp_back_value,
   output      logic [dbs_pkg::COUNT_W-1:0]       rsp_count,
   output      logic                              rsp_is_empty
);
   import dbs_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   rsp_type           rsp;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic [DATA_W-1:0] rd_data;
   logic [IDX_W-1:0]  head;
   logic [CNT_W-1:0]  offset;
   logic [DATA_W-1:0] value;
   logic [IDX_W-1:0]  slot;
   logic              match;

   dbs_ctrl #(
      .DEPTH (DEPTH),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .req_value (req_value),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_data   (rd_data),
      .head      (head),
      .offset    (offset),
      .value     (value),
      .slot      (slot),
      .match     (match)
   );

   dbs_unit #(
      .DEPTH (DEPTH),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
   ) u_unit (
      .head    (head),
      .offset  (offset),
      .rd_data (rd_data),
      .value   (value),
      .slot    (slot),
      .match   (match)
   );

   dbs_ram #(
      .DEPTH (DEPTH),
      .IDX_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (slot),
      .rd_data (rd_data)
   );

   assign rsp_status      = rsp.status;
   assign rsp_found       = rsp.found;
   assign rsp_front_value = rsp.front_value;
   assign rsp_back_value  = rsp.back_value;
   assign rsp_count       = rsp.count;
   assign rsp_is_empty    = rsp.is_empty;

endmodule

`default_nettype wire

/* rtl/dbs_ram.sv */
// ----------------------------------------------------------------------------
// dbs_ram
// Entry storage: one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dbs_ram #(
   parameter int DEPTH = dbs_pkg::DEPTH_DEFAULT,
   parameter int IDX_W = $clog2(DEPTH)
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [IDX_W-1:0]          wr_addr,
   input  wire logic [dbs_pkg::DATA_W-1:0] wr_data,
   input  wire logic [IDX_W-1:0]          rd_addr,
   output      logic [dbs_pkg::DATA_W-1:0] rd_data
);
   import dbs_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/dbs_unit.sv */
// ----------------------------------------------------------------------------
// dbs_unit
// Shared slot adder with ring wrap and the value comparator.
// ----------------------------------------------------------------------------
`default_nettype none

module dbs_unit #(
   parameter int DEPTH = dbs_pkg::DEPTH_DEFAULT,
   parameter int IDX_W = $clog2(DEPTH),
   parameter int CNT_W = $clog2(DEPTH + 1)
) (
   input  wire logic [IDX_W-1:0]           head,
   input  wire logic [CNT_W-1:0]           offset,
   input  wire logic [dbs_pkg::DATA_W-1:0] rd_data,
   input  wire logic [dbs_pkg::DATA_W-1:0] value,
   output      logic [IDX_W-1:0]           slot,
   output      logic                       match
);
   import dbs_pkg::*;

   localparam int SUM_W = CNT_W + 1;

   logic [SUM_W-1:0] sum;

   always_comb begin
      sum = SUM_W'(head) + SUM_W'(offset);
      if (sum >= SUM_W'(DEPTH)) begin
         slot = IDX_W'(sum - SUM_W'(DEPTH));
      end else begin
         slot = IDX_W'(sum);
      end
   end

   assign match = (rd_data == value);

endmodule

`default_nettype wire

/* rtl/dbs_ctrl.sv */
// ----------------------------------------------------------------------------
// dbs_ctrl
// Sequencer: runs each operation through the shared unit and the entry
// storage, then reads the front and back entries for the result item.
// ----------------------------------------------------------------------------
`default_nettype none

module dbs_ctrl #(
   parameter int DEPTH = dbs_pkg::DEPTH_DEFAULT,
   parameter int IDX_W = $clog2(DEPTH),
   parameter int CNT_W = $clog2(DEPTH + 1)
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output      logic                       req_ready,
   input  wire logic [dbs_pkg::KIND_W-1:0] req_kind,
   input  wire logic [dbs_pkg::DATA_W-1:0] req_value,
   output      logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   output      dbs_pkg::rsp_type           rsp,
   output      logic                       wr_en,
   output      logic [IDX_W-1:0]           wr_addr,
   output      logic [dbs_pkg::DATA_W-1:0] wr_data,
   input  wire logic [dbs_pkg::DATA_W-1:0] rd_data,
   output      logic [IDX_W-1:0]           head,
   output      logic [CNT_W-1:0]           offset,
   output      logic [dbs_pkg::DATA_W-1:0] value,
   input  wire logic [IDX_W-1:0]           slot,
   input  wire logic                       match
);
   import dbs_pkg::*;

   state_type           state_ff, state_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [DATA_W-1:0]   value_ff, value_in;
   logic [IDX_W-1:0]    head_ff, head_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic                pend_ff, pend_in;
   logic [IDX_W-1:0]    last_addr_ff, last_addr_in;
   logic [IDX_W-1:0]    prev_addr_ff, prev_addr_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                found_ff, found_in;
   logic [DATA_W-1:0]   front_ff, front_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic             full;
   logic             empty;
   logic             idx_end;
   logic             hit;
   logic [CNT_W-1:0] idx_inc;
   logic             shift_more;
   logic             rsp_free;
   logic             is_search;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign empty      = (count_ff == '0);
   assign idx_end    = (idx_ff == count_ff);
   assign hit        = pend_ff && match;
   assign idx_inc    = idx_ff + CNT_W'(1);
   assign shift_more = (idx_inc < count_ff);
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign is_search  = (kind_ff == KIND_CONTAINS) || (kind_ff == KIND_REMOVE);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            state_in = is_search ? ST_SEARCH : ST_RD_FRONT;
         end
         ST_SEARCH: begin
            if (hit) begin
               state_in = (kind_ff == KIND_REMOVE) ? ST_SHIFT : ST_RD_FRONT;
            end else if (idx_end) begin
               state_in = ST_RD_FRONT;
            end
         end
         ST_SHIFT: begin
            if (!shift_more && !pend_ff) begin
               state_in = ST_RD_FRONT;
            end
         end
         ST_RD_FRONT: state_in = ST_RD_BACK;
         ST_RD_BACK:  state_in = ST_FINISH;
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      kind_in      = kind_ff;
      value_in     = value_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      last_addr_in = last_addr_ff;
      prev_addr_in = prev_addr_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      front_in     = front_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = slot;
      wr_data      = value_ff;
      offset       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               kind_in   = req_kind;
               value_in  = req_value;
               status_in = STATUS_OK;
               found_in  = 1'b0;
            end
         end
         ST_DISPATCH: begin
            case (kind_ff) inside
               KIND_PUSH_FRONT: begin
                  offset = CNT_W'(DEPTH - 1);
                  if (full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     head_in  = slot;
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               KIND_PUSH_BACK: begin
                  offset = count_ff;
                  if (full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               KIND_POP_FRONT: begin
                  offset = CNT_W'(1);
                  if (empty) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     head_in  = slot;
                     count_in = count_ff - CNT_W'(1);
                  end
               end
               KIND_POP_BACK: begin
                  if (empty) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     count_in = count_ff - CNT_W'(1);
                  end
               end
               KIND_CONTAINS, KIND_REMOVE: begin
                  idx_in  = '0;
                  pend_in = 1'b0;
               end
               default: begin
               end
            endcase
         end
         ST_SEARCH: begin
            offset = idx_ff;
            if (hit) begin
               found_in = 1'b1;
               idx_in   = idx_ff - CNT_W'(1);
               pend_in  = 1'b0;
            end else if (idx_end) begin
               status_in = (kind_ff == KIND_REMOVE) ? STATUS_NOT_FOUND : STATUS_OK;
            end else begin
               pend_in      = 1'b1;
               idx_in       = idx_inc;
               last_addr_in = slot;
            end
         end
         ST_SHIFT: begin
            offset  = idx_inc;
            wr_en   = pend_ff;
            wr_addr = prev_addr_ff;
            wr_data = rd_data;
            if (shift_more) begin
               idx_in       = idx_inc;
               pend_in      = 1'b1;
               prev_addr_in = last_addr_ff;
               last_addr_in = slot;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
         end
         ST_RD_FRONT: begin
            offset = '0;
         end
         ST_RD_BACK: begin
            offset   = empty ? '0 : count_ff - CNT_W'(1);
            front_in = rd_data;
         end
         ST_FINISH: begin
            // same address as before so the back entry stays on the read port
            offset = empty ? '0 : count_ff - CNT_W'(1);
            if (rsp_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = status_ff;
               rsp_in.found       = found_ff;
               rsp_in.front_value = empty ? '0 : front_ff;
               rsp_in.back_value  = empty ? '0 : rd_data;
               rsp_in.count       = COUNT_W'(count_ff);
               rsp_in.is_empty    = empty;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      value_ff     <= value_in;
      idx_ff       <= idx_in;
      last_addr_ff <= last_addr_in;
      prev_addr_ff <= prev_addr_in;
      status_ff    <= status_in;
      found_ff     <= found_in;
      front_ff     <= front_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign head      = head_ff;
   assign value     = value_ff;

endmodule

`default_nettype wire

/* rtl/dbs_checker.sv */
// ----------------------------------------------------------------------------
// dbs_checker
// Port-level checks on the store, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dbs_checker #(
   parameter int DEPTH = dbs_pkg::DEPTH_DEFAULT
) (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_ready,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic [dbs_pkg::STATUS_W-1:0]      rsp_status,
   input wire logic                              rsp_found,
   input wire logic signed [dbs_pkg::DATA_W-1:0] rsp_front_value,
   input wire logic signed [dbs_pkg::DATA_W-1:0] rsp_back_value,
   input wire logic [dbs_pkg::COUNT_W-1:0]       rsp_count,
   input wire logic                              rsp_is_empty
);
   import dbs_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_found) && $stable(rsp_front_value)
         && $stable(rsp_back_value) && $stable(rsp_count) && $stable(rsp_is_empty))
      else $error("result item changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready while an item is in work");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |->
         rsp_count == '0 && rsp_front_value == '0 && rsp_back_value == '0)
      else $error("empty store reports values");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_status == STATUS_OK)
      else $error("found with error status");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |->
         rsp_count == COUNT_W'(DEPTH) && !rsp_is_empty)
      else $error("full status with wrong count");

endmodule

bind deque_bag_store_core dbs_checker #(
   .DEPTH (DEPTH)
) u_dbs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_status      (rsp_status),
   .rsp_found       (rsp_found),
   .rsp_front_value (rsp_front_value),
   .rsp_back_value  (rsp_back_value),
   .rsp_count       (rsp_count),
   .rsp_is_empty    (rsp_is_empty)
);

`default_nettype wire
